@@ hdl/exprtok_pkg.sv @@
package exprtok_pkg;

  // Token kind codes as they appear on the result channel.
  typedef enum logic [3:0] {
    KIND_NUMBER = 4'd0,
    KIND_IDENT  = 4'd1,
    KIND_I32    = 4'd2,
    KIND_LPAREN = 4'd3,
    KIND_RPAREN = 4'd4,
    KIND_PLUS   = 4'd5,
    KIND_MINUS  = 4'd6,
    KIND_STAR   = 4'd7,
    KIND_SLASH  = 4'd8,
    KIND_CARET  = 4'd9,
    KIND_COLON  = 4'd10,
    KIND_SEMI   = 4'd11,
    KIND_END    = 4'd12,
    KIND_ERROR  = 4'd13
  } kind_e;

  // Scanner mode, one-hot.
  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_NUM   = 4'b0010,
    MODE_IDENT = 4'b0100,
    MODE_HALT  = 4'b1000
  } mode_e;

  // Progress through the keyword "i32".
  typedef enum logic [1:0] {
    KW_NONE = 2'd0,
    KW_I    = 2'd1,
    KW_I3   = 2'd2,
    KW_I32  = 2'd3
  } kw_e;

  localparam int unsigned KW_LEN = 3;

  // Output queue geometry.
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_3     = 8'h33;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
  endfunction

  // Punctuation lookup: valid flag in the top bit, kind below.
  function automatic logic [4:0] punct_lookup(input logic [7:0] c);
    logic [4:0] r;
    unique case (c)
      8'h28:   r = {1'b1, KIND_LPAREN};
      8'h29:   r = {1'b1, KIND_RPAREN};
      8'h2B:   r = {1'b1, KIND_PLUS};
      8'h2D:   r = {1'b1, KIND_MINUS};
      8'h2A:   r = {1'b1, KIND_STAR};
      8'h2F:   r = {1'b1, KIND_SLASH};
      8'h5E:   r = {1'b1, KIND_CARET};
      8'h3A:   r = {1'b1, KIND_COLON};
      8'h3B:   r = {1'b1, KIND_SEMI};
      default: r = {1'b0, KIND_ERROR};
    endcase
    return r;
  endfunction

endpackage

@@ hdl/exprtok_fifo.sv @@
module exprtok_fifo
  import exprtok_pkg::*;
#(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Write side: zero, one or two entries per cycle.
  input  logic [1:0]        push_n_i,
  input  logic [DATA_W-1:0] push_data0_i,
  input  logic [DATA_W-1:0] push_data1_i,
  output logic              room_o,
  // Read side.
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] out_data_o
);

  logic [DATA_W-1:0]   mem_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [OQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OQ_CNT_W-1:0] count_q, count_d;
  logic                pop;

  // Room for a pair of entries, judged on the registered fill level.
  assign room_o      = count_q <= OQ_CNT_W'(OQ_DEPTH - 2);
  assign out_valid_o = count_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  // Pointer and fill level updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q + OQ_PTR_W'(push_n_i);
    rd_ptr_d = rd_ptr_q + OQ_PTR_W'(pop);
    count_d  = count_q + OQ_CNT_W'(push_n_i) - OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage; the second entry of a pair lands just after the first.
  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push_data0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_q + OQ_PTR_W'(1)] <= push_data1_i;
    end
  end

`ifndef SYNTHESIS
  // The fill level never passes the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= OQ_CNT_W'(OQ_DEPTH))
    else $error("output queue overfilled");

  // Entries are only written when the queue reported room.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i != 2'd0) |-> room_o)
    else $error("write into output queue without room");
`endif

endmodule

@@ hdl/expression_tokenizer.sv @@
// Channel | Direction | Handshake                | Payload
// input   | in        | in_valid_i / in_ready_o   | in_char_i, end_of_input_i
// result  | out       | out_valid_o / out_ready_i | token_kind_o ... last_of_run_o
//
// A byte is registered on acceptance and scanned from that register once the
// output queue has room; its tokens are written into the output queue and are
// taken from there. One byte is taken per cycle as long as the result side
// keeps up; a byte that ends a run with a token of its own gives two tokens and
// the single result port then sets the pace. rst_ni clears the scanner and the
// queue at once. After an error token every transaction is taken and dropped
// until reset.
module expression_tokenizer
  import exprtok_pkg::*;
#(
  parameter int unsigned POS_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_char_i,
  input  logic                 end_of_input_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [3:0]           token_kind_o,
  output logic [POS_WIDTH-1:0] start_offset_o,
  output logic [POS_WIDTH-1:0] token_length_o,
  output logic [POS_WIDTH-1:0] line_number_o,
  output logic [POS_WIDTH-1:0] column_number_o,
  output logic [7:0]           bad_char_o,
  output logic                 last_of_run_o
);

  typedef logic [POS_WIDTH-1:0] pos_t;

  typedef struct packed {
    kind_e      kind;
    pos_t       start;
    pos_t       len;
    pos_t       line;
    pos_t       col;
    logic [7:0] bad;
    logic       last;
  } tok_t;

  localparam int unsigned TOK_W = $bits(tok_t);

  function automatic pos_t sat_inc(input pos_t v);
    return (&v) ? v : v + POS_WIDTH'(1);
  endfunction

  // Input register.
  logic       in_vld_q;
  logic [7:0] char_q;
  logic       eoi_q;

  // Scanner state.
  mode_e mode_q, mode_d;
  kw_e   kw_q, kw_d;
  pos_t  run_start_q, run_start_d;
  pos_t  run_len_q, run_len_d;
  pos_t  run_line_q, run_line_d;
  pos_t  run_col_q, run_col_d;
  pos_t  offset_q, offset_d;
  pos_t  line_q, line_d;
  pos_t  col_q, col_d;

  logic       room;
  logic       adv;
  logic       active;
  logic       extend;
  logic       flush_vld;
  logic       own_vld;
  logic [4:0] punct;
  tok_t       flush_tok;
  tok_t       own_tok;
  tok_t       push_tok0;
  tok_t       push_tok1;
  tok_t       pop_tok;
  logic [1:0] push_n;

  // The input register frees up whenever its byte moves on.
  assign adv        = in_vld_q && room;
  assign in_ready_o = !in_vld_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= in_char_i;
      eoi_q  <= end_of_input_i;
    end
  end

  // Classification of the registered byte.
  assign active = adv && (mode_q != MODE_HALT);
  assign punct  = punct_lookup(char_q);
  assign extend = !eoi_q &&
                  (((mode_q == MODE_NUM) && is_digit(char_q)) ||
                   ((mode_q == MODE_IDENT) && (is_digit(char_q) || is_letter(char_q))));

  // Token for the pending run, emitted when the byte cannot extend it.
  always_comb begin
    flush_vld       = active && !extend &&
                      ((mode_q == MODE_NUM) || (mode_q == MODE_IDENT));
    flush_tok.start = run_start_q;
    flush_tok.len   = run_len_q;
    flush_tok.line  = run_line_q;
    flush_tok.col   = run_col_q;
    flush_tok.bad   = 8'h00;
    flush_tok.last  = 1'b0;
    if (mode_q == MODE_NUM) begin
      flush_tok.kind = KIND_NUMBER;
    end else if ((kw_q == KW_I32) && (run_len_q == POS_WIDTH'(KW_LEN))) begin
      flush_tok.kind = KIND_I32;
    end else begin
      flush_tok.kind = KIND_IDENT;
    end
  end

  // Token of the byte itself: end marker, punctuation or error.
  always_comb begin
    own_tok.start = offset_q;
    own_tok.line  = line_q;
    own_tok.col   = col_q;
    own_tok.last  = 1'b1;
    own_tok.bad   = 8'h00;
    own_tok.len   = POS_WIDTH'(1);
    own_tok.kind  = KIND_ERROR;
    own_vld       = 1'b0;
    if (active) begin
      if (eoi_q) begin
        own_vld      = 1'b1;
        own_tok.kind = KIND_END;
        own_tok.len  = '0;
      end else if (!extend && !is_blank(char_q) && !is_digit(char_q) &&
                   !is_letter(char_q)) begin
        own_vld = 1'b1;
        if (punct[4]) begin
          own_tok.kind = kind_e'(punct[3:0]);
        end else begin
          own_tok.bad = char_q;
        end
      end
    end
  end

  // Pack up to two tokens for the output queue, in order.
  always_comb begin
    push_n         = {1'b0, flush_vld} + {1'b0, own_vld};
    push_tok0      = flush_vld ? flush_tok : own_tok;
    push_tok0.last = !(flush_vld && own_vld);
    push_tok1      = own_tok;
  end

  // Next scanner state.
  always_comb begin
    mode_d      = mode_q;
    kw_d        = kw_q;
    run_start_d = run_start_q;
    run_len_d   = run_len_q;
    run_line_d  = run_line_q;
    run_col_d   = run_col_q;
    offset_d    = offset_q;
    line_d      = line_q;
    col_d       = col_q;
    if (active) begin
      if (eoi_q) begin
        // End of text: clear the run (a pending run is flushed as a token) and restart the position counters.
        mode_d    = MODE_IDLE;
        kw_d      = KW_NONE;
        run_len_d = '0;
        offset_d  = '0;
        line_d    = '0;
        col_d     = '0;
      end else begin
        if (extend) begin
          run_len_d = sat_inc(run_len_q);
          if ((kw_q == KW_I) && (char_q == CH_3)) begin
            kw_d = KW_I3;
          end else if ((kw_q == KW_I3) && (char_q == CH_2)) begin
            kw_d = KW_I32;
          end else begin
            kw_d = KW_NONE;
          end
        end else begin
          mode_d    = MODE_IDLE;
          kw_d      = KW_NONE;
          run_len_d = '0;
          if (is_digit(char_q) || is_letter(char_q)) begin
            // A new run starts at this byte.
            mode_d      = is_digit(char_q) ? MODE_NUM : MODE_IDENT;
            run_start_d = offset_q;
            run_len_d   = POS_WIDTH'(1);
            run_line_d  = line_q;
            run_col_d   = col_q;
            kw_d        = (is_letter(char_q) && (char_q == CH_I)) ? KW_I : KW_NONE;
          end else if (!is_blank(char_q) && !punct[4]) begin
            mode_d = MODE_HALT;
          end
        end
        offset_d = sat_inc(offset_q);
        if (char_q == CH_NL) begin
          line_d = sat_inc(line_q);
          col_d  = '0;
        end else begin
          col_d = sat_inc(col_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      kw_q        <= KW_NONE;
      run_start_q <= '0;
      run_len_q   <= '0;
      run_line_q  <= '0;
      run_col_q   <= '0;
      offset_q    <= '0;
      line_q      <= '0;
      col_q       <= '0;
    end else begin
      mode_q      <= mode_d;
      kw_q        <= kw_d;
      run_start_q <= run_start_d;
      run_len_q   <= run_len_d;
      run_line_q  <= run_line_d;
      run_col_q   <= run_col_d;
      offset_q    <= offset_d;
      line_q      <= line_d;
      col_q       <= col_d;
    end
  end

  // Output queue; it separates the scanner from a stalled consumer.
  exprtok_fifo #(
    .DATA_W(TOK_W)
  ) u_oq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .push_data0_i(push_tok0),
    .push_data1_i(push_tok1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (pop_tok)
  );

  assign token_kind_o    = pop_tok.kind;
  assign start_offset_o  = pop_tok.start;
  assign token_length_o  = pop_tok.len;
  assign line_number_o   = pop_tok.line;
  assign column_number_o = pop_tok.col;
  assign bad_char_o      = pop_tok.bad;
  assign last_of_run_o   = pop_tok.last;

`ifndef SYNTHESIS
  // A halted scanner produces nothing.
  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_HALT) |-> (push_n == 2'd0))
    else $error("token produced while halted");

  // An end marker leaves the position counters at zero.
  a_end_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active && eoi_q) |=> ((offset_q == '0) && (line_q == '0) && (col_q == '0)))
    else $error("counters not restarted after end token");

  // A pair of tokens always starts with the flushed run.
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n == 2'd2) |-> ((push_tok0.kind == KIND_NUMBER) ||
                          (push_tok0.kind == KIND_IDENT) ||
                          (push_tok0.kind == KIND_I32)))
    else $error("token pair does not start with a run");
`endif

endmodule
